@@ hdl/pidw_pkg.sv @@
// Shared types and constants for the port idle watchdog bank.
// Used by every module under hdl; depends on nothing else.
package pidw_pkg;

    localparam int NUM_PORTS_DEF = 16;
    localparam int COUNT_W       = 32;
    localparam int TIMEOUT_W     = 31;
    localparam int TICK_W        = 16;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 32;

    // action codes
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_STOP    = 2'd1;
    localparam logic [1:0] ACT_REQUEST = 2'd2;
    localparam logic [1:0] ACT_TICK    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TICK    = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] port_id;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         close_port;
        logic [COUNT_W-1:0] idle_time;
        logic               last;
    } out_item_t;

    // result of the shared update unit
    typedef struct packed {
        logic [COUNT_W-1:0] sum;
        logic               over;
    } upd_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

@@ hdl/port_idle_watchdog_bank_unit.sv @@
// Port idle watchdog bank, top level. Start, stop and request items are
// applied as they are accepted. A tick, when the watchdog is enabled, walks
// the ports through one shared add/compare unit and the counter store's
// single read port, one port per cycle while the result side does not stall;
// no new item is accepted until the walk ends. Close results leave in
// ascending port order; one result is held back until the next is found or
// the walk ends, so that last can be set on the final one.
// Depends on pidw_pkg, pidw_count_mem and pidw_update.
module port_idle_watchdog_bank_unit #(
    parameter int NUM_PORTS = pidw_pkg::NUM_PORTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  pidw_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output pidw_pkg::out_item_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pidw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pidw_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam logic [PORT_W-1:0] LAST_PORT = PORT_W'(NUM_PORTS - 1);

    // configuration
    logic                           enable_reg,  enable_next;
    logic [pidw_pkg::TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [pidw_pkg::TICK_W-1:0]    tick_reg,    tick_next;

    // sequencer and port state
    pidw_pkg::state_t               state_reg, state_next;
    logic [PORT_W-1:0]              port_reg,  port_next;
    logic [NUM_PORTS-1:0]           running_reg, running_next;

    // held-back result and output register
    logic                           pend_valid_reg, pend_valid_next;
    logic [3:0]                     pend_port_reg,  pend_port_next;
    logic [pidw_pkg::COUNT_W-1:0]   pend_count_reg, pend_count_next;
    logic                           out_valid_reg,  out_valid_next;
    pidw_pkg::out_item_t            out_reg,        out_next;

    // store and unit
    logic                           wr_en;
    logic [PORT_W-1:0]              wr_addr;
    logic [pidw_pkg::COUNT_W-1:0]   wr_data;
    logic [PORT_W-1:0]              rd_addr;
    logic [pidw_pkg::COUNT_W-1:0]   rd_data;
    pidw_pkg::upd_status_t          upd;

    logic                           accept;
    logic                           port_ok;
    logic [PORT_W-1:0]              in_port;
    logic                           out_free;
    logic                           hit;
    logic                           can_go;
    logic                           at_last;

    pidw_count_mem #(
        .NUM_PORTS (NUM_PORTS)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pidw_update u_update (
        .count      (rd_data),
        .tick_ms    (tick_reg),
        .timeout_ms (timeout_reg),
        .status     (upd)
    );

    assign s_ready   = (state_reg == pidw_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign accept   = s_valid && s_ready;
    assign port_ok  = {3'b000, s_data.port_id} < 7'(NUM_PORTS);
    assign in_port  = PORT_W'(s_data.port_id);
    assign out_free = !out_valid_reg || m_ready;
    assign at_last  = (port_reg == LAST_PORT);
    assign hit      = running_reg[port_reg] && upd.over;
    assign can_go   = !hit || !pend_valid_reg || out_free;

    // configuration writes
    always_comb begin
        enable_next  = enable_reg;
        timeout_next = timeout_reg;
        tick_next    = tick_reg;
        if (cfg_valid) begin
            case (cfg_addr)
                pidw_pkg::CFG_ENABLE:  enable_next  = cfg_data[0];
                pidw_pkg::CFG_TIMEOUT: timeout_next = cfg_data[pidw_pkg::TIMEOUT_W-1:0];
                pidw_pkg::CFG_TICK:    tick_next    = cfg_data[pidw_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pidw_pkg::ST_IDLE: begin
                if (accept && s_data.action == pidw_pkg::ACT_TICK && enable_reg) begin
                    state_next = pidw_pkg::ST_SCAN;
                end
            end
            pidw_pkg::ST_SCAN: begin
                if (can_go && at_last) begin
                    state_next = pidw_pkg::ST_FLUSH;
                end
            end
            pidw_pkg::ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = pidw_pkg::ST_IDLE;
                end
            end
            default: state_next = pidw_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        port_next       = port_reg;
        running_next    = running_reg;
        pend_valid_next = pend_valid_reg;
        pend_port_next  = pend_port_reg;
        pend_count_next = pend_count_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        wr_en           = 1'b0;
        wr_addr         = port_reg;
        wr_data         = upd.sum;
        rd_addr         = '0;
        case (state_reg)
            pidw_pkg::ST_IDLE: begin
                port_next = '0;
                if (accept && port_ok) begin
                    wr_addr = in_port;
                    wr_data = '0;
                    case (s_data.action)
                        pidw_pkg::ACT_START: begin
                            running_next[in_port] = 1'b1;
                            wr_en = 1'b1;
                        end
                        pidw_pkg::ACT_STOP:    running_next[in_port] = 1'b0;
                        pidw_pkg::ACT_REQUEST: wr_en = 1'b1;
                        default: ;
                    endcase
                end
            end
            pidw_pkg::ST_SCAN: begin
                if (can_go) begin
                    wr_en   = running_reg[port_reg];
                    rd_addr = at_last ? '0 : port_reg + PORT_W'(1);
                    port_next = port_reg + PORT_W'(1);
                    if (hit) begin
                        // release the held result, hold this one
                        if (pend_valid_reg) begin
                            out_next.close_port = pend_port_reg;
                            out_next.idle_time  = pend_count_reg;
                            out_next.last       = 1'b0;
                            out_valid_next      = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_port_next  = 4'(port_reg);
                        pend_count_next = upd.sum;
                    end
                end else begin
                    // re-read this port while the result side stalls
                    rd_addr = port_reg;
                end
            end
            pidw_pkg::ST_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    out_next.close_port = pend_port_reg;
                    out_next.idle_time  = pend_count_reg;
                    out_next.last       = 1'b1;
                    out_valid_next      = 1'b1;
                    pend_valid_next     = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            timeout_reg    <= '0;
            tick_reg       <= pidw_pkg::TICK_W'(1);
            state_reg      <= pidw_pkg::ST_IDLE;
            port_reg       <= '0;
            running_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            enable_reg     <= enable_next;
            timeout_reg    <= timeout_next;
            tick_reg       <= tick_next;
            state_reg      <= state_next;
            port_reg       <= port_next;
            running_reg    <= running_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_port_reg  <= pend_port_next;
        pend_count_reg <= pend_count_next;
        out_reg        <= out_next;
    end

endmodule

@@ hdl/pidw_update.sv @@
// Shared saturating add and timeout compare for one idle counter.
// Depends on pidw_pkg.
module pidw_update (
    input  logic [pidw_pkg::COUNT_W-1:0]   count,
    input  logic [pidw_pkg::TICK_W-1:0]    tick_ms,
    input  logic [pidw_pkg::TIMEOUT_W-1:0] timeout_ms,
    output pidw_pkg::upd_status_t          status
);

    logic [pidw_pkg::COUNT_W:0] wide_sum;

    always_comb begin
        wide_sum = {1'b0, count} + {{(pidw_pkg::COUNT_W + 1 - pidw_pkg::TICK_W){1'b0}}, tick_ms};
        // saturate on carry out
        if (wide_sum[pidw_pkg::COUNT_W]) begin
            status.sum = {pidw_pkg::COUNT_W{1'b1}};
        end else begin
            status.sum = wide_sum[pidw_pkg::COUNT_W-1:0];
        end
        status.over = status.sum >
            {{(pidw_pkg::COUNT_W - pidw_pkg::TIMEOUT_W){1'b0}}, timeout_ms};
    end

endmodule

@@ hdl/pidw_count_mem.sv @@
// Idle counter store: one write and one registered read port, with a
// valid bit per entry so that unwritten entries read as zero.
// Depends on pidw_pkg.
module pidw_count_mem #(
    parameter int NUM_PORTS = pidw_pkg::NUM_PORTS_DEF,
    localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [PORT_W-1:0]             wr_addr,
    input  logic [pidw_pkg::COUNT_W-1:0]  wr_data,
    input  logic [PORT_W-1:0]             rd_addr,
    output logic [pidw_pkg::COUNT_W-1:0]  rd_data
);

    logic [pidw_pkg::COUNT_W-1:0] mem [NUM_PORTS];
    logic [NUM_PORTS-1:0]         valid_reg;
    logic [NUM_PORTS-1:0]         valid_next;
    logic [pidw_pkg::COUNT_W-1:0] rd_data_reg;
    logic                         rd_valid_reg;
    logic                         rd_valid_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
        rd_valid_next = valid_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ tb/sv/port_idle_watchdog_bank_unit_tb.sv @@
// Self-checking testbench for port_idle_watchdog_bank_unit: random valid/ready traffic,
// a watchdog model that applies each accepted item and an in-order check of every close result.
// Depends on pidw_pkg and the unit itself.
module port_idle_watchdog_bank_unit_tb;

    localparam int          N_PORTS      = pidw_pkg::NUM_PORTS_DEF;
    localparam int          SETTLE_CYC   = 2 * (N_PORTS + 2) + 4;
    localparam int          CYCLE_LIMIT  = 200_000;
    localparam int          IDLE_PCT     = 18;
    localparam logic [31:0] COUNT_SAT    = 32'hFFFF_FFFF;
    localparam logic [30:0] TIMEOUT_TOP  = 31'h7FFF_FFFF;
    localparam logic [15:0] TICK_TOP     = 16'hFFFF;
    localparam logic [pidw_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    pidw_pkg::in_item_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    pidw_pkg::out_item_t             m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pidw_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [pidw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // watchdog model state and registers
    logic                           port_running [N_PORTS];
    logic [pidw_pkg::COUNT_W-1:0]   port_idle_ms [N_PORTS];
    logic                           wd_enable;
    logic [pidw_pkg::TIMEOUT_W-1:0] wd_timeout;
    logic [pidw_pkg::TICK_W-1:0]    wd_tick;

    pidw_pkg::in_item_t  pending_items_q [$];
    pidw_pkg::out_item_t close_expect_q  [$];
    int        pushed_cnt   = 0;
    int        accepted_cnt = 0;
    int        cfg_done_cnt = 0;
    int        fault_cnt    = 0;
    int        cycle_cnt    = 0;
    bit        steady_flow  = 1'b0;

    port_idle_watchdog_bank_unit #(.NUM_PORTS(N_PORTS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one accepted item to the model; a tick queues its close results.
    task automatic watchdog_apply(input pidw_pkg::in_item_t it);
        pidw_pkg::out_item_t batch [$];
        pidw_pkg::out_item_t res;
        case (it.action)
            pidw_pkg::ACT_START: begin
                port_running[it.port_id] = 1'b1;
                port_idle_ms[it.port_id] = '0;
            end
            pidw_pkg::ACT_STOP: begin
                port_running[it.port_id] = 1'b0;
            end
            pidw_pkg::ACT_REQUEST: begin
                port_idle_ms[it.port_id] = '0;
            end
            default: begin
                if (wd_enable) begin
                    for (int p = 0; p < N_PORTS; p++) begin
                        if (port_running[p]) begin
                            if (port_idle_ms[p] > COUNT_SAT - {16'd0, wd_tick})
                                port_idle_ms[p] = COUNT_SAT;
                            else
                                port_idle_ms[p] = port_idle_ms[p] + {16'd0, wd_tick};
                            if (port_idle_ms[p] > {1'b0, wd_timeout}) begin
                                res.close_port = 4'(p);
                                res.idle_time  = port_idle_ms[p];
                                res.last       = 1'b0;
                                batch = {batch, res};
                            end
                        end
                    end
                    if (batch.size() > 0) begin
                        res = batch[batch.size() - 1];
                        res.last = 1'b1;
                        batch[batch.size() - 1] = res;
                    end
                    foreach (batch[i]) close_expect_q = {close_expect_q, batch[i]};
                end
            end
        endcase
    endtask

    // sender: hold an offered item until taken, then maybe idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                watchdog_apply(s_data);
                accepted_cnt++;
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (pending_items_q.size() > 0 &&
                         (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
                s_valid <= 1'b1;
                s_data  <= pending_items_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: check each close result against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (close_expect_q.size() == 0) begin
                    $display("%0t: expected no close result, got port %0d idle %0d last %0b",
                             $time, m_data.close_port, m_data.idle_time, m_data.last);
                    fault_cnt++;
                end else begin
                    if (m_data.close_port !== close_expect_q[0].close_port ||
                        m_data.idle_time  !== close_expect_q[0].idle_time  ||
                        m_data.last       !== close_expect_q[0].last) begin
                        $display({"%0t: close result mismatch: expected port %0d idle %0d ",
                                  "last %0b, got port %0d idle %0d last %0b"},
                                 $time, close_expect_q[0].close_port,
                                 close_expect_q[0].idle_time, close_expect_q[0].last,
                                 m_data.close_port, m_data.idle_time, m_data.last);
                        fault_cnt++;
                    end
                    void'(close_expect_q.pop_front());
                end
            end
            m_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // register writes land in the model at the accepting edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                pidw_pkg::CFG_ENABLE:  wd_enable  = cfg_data[0];
                pidw_pkg::CFG_TIMEOUT: wd_timeout = cfg_data[pidw_pkg::TIMEOUT_W-1:0];
                pidw_pkg::CFG_TICK:    wd_tick    = cfg_data[pidw_pkg::TICK_W-1:0];
                default: ;
            endcase
            cfg_valid <= 1'b0;
            cfg_done_cnt++;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input logic [pidw_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [pidw_pkg::CFG_DATA_W-1:0] value);
        int target;
        target = cfg_done_cnt + 1;
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        while (cfg_done_cnt != target) @(negedge aclk);
    endtask

    // unused upper data bits are filled with noise; the block must drop them
    task automatic set_watchdog(input bit en, input logic [30:0] tmo, input logic [15:0] tk);
        write_reg(pidw_pkg::CFG_ENABLE,  {31'($urandom()), en});
        write_reg(pidw_pkg::CFG_TIMEOUT, {1'($urandom()), tmo});
        write_reg(pidw_pkg::CFG_TICK,    {16'($urandom()), tk});
    endtask

    task automatic queue_item(input logic [1:0] act, input logic [3:0] port);
        pidw_pkg::in_item_t it;
        it.action  = act;
        it.port_id = port;
        pending_items_q = {pending_items_q, it};
        pushed_cnt++;
    endtask

    // wait for every item and close result, then let a walk in flight finish
    task automatic settle();
        while (accepted_cnt != pushed_cnt || close_expect_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    initial begin : stimulus
        int   r;
        logic [1:0] act;
        for (int p = 0; p < N_PORTS; p++) begin
            port_running[p] = 1'b0;
            port_idle_ms[p] = '0;
        end
        wd_enable  = 1'b0;
        wd_timeout = '0;
        wd_tick    = 16'd1;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: watchdog off, ticks do nothing
        queue_item(pidw_pkg::ACT_TICK, 4'd9);
        queue_item(pidw_pkg::ACT_START, 4'd0);
        queue_item(pidw_pkg::ACT_TICK, 4'd0);
        queue_item(pidw_pkg::ACT_STOP, 4'd0);
        settle();

        set_watchdog(1'b1, 31'd0, 16'd1);
        @(negedge aclk);
        queue_item(pidw_pkg::ACT_START, 4'd0);
        queue_item(pidw_pkg::ACT_START, 4'd15);
        queue_item(pidw_pkg::ACT_TICK, 4'd15);
        queue_item(pidw_pkg::ACT_REQUEST, 4'd15);
        queue_item(pidw_pkg::ACT_TICK, 4'd0);
        queue_item(pidw_pkg::ACT_START, 4'd0);     // restart of a running port
        queue_item(pidw_pkg::ACT_TICK, 4'd3);
        queue_item(pidw_pkg::ACT_STOP, 4'd15);
        queue_item(pidw_pkg::ACT_TICK, 4'd0);
        queue_item(pidw_pkg::ACT_STOP, 4'd15);     // stop of an idle port
        queue_item(pidw_pkg::ACT_REQUEST, 4'd15);  // request on a stopped port
        queue_item(pidw_pkg::ACT_START, 4'd15);
        queue_item(pidw_pkg::ACT_TICK, 4'd12);
        settle();

        // zero tick interval: counters hold but still get checked
        set_watchdog(1'b1, 31'd0, 16'd0);
        @(negedge aclk);
        queue_item(pidw_pkg::ACT_TICK, 4'd5);
        queue_item(pidw_pkg::ACT_STOP, 4'd0);
        queue_item(pidw_pkg::ACT_STOP, 4'd15);
        queue_item(pidw_pkg::ACT_TICK, 4'd10);
        settle();

        write_reg(CFG_SPARE, $urandom());
        write_reg(pidw_pkg::CFG_ENABLE, 32'hFFFF_FFFE);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_watchdog(1'b1, 31'($urandom_range(20)), 16'($urandom_range(8, 1)));
                1: set_watchdog(1'b1, 31'd0, TICK_TOP);
                2: set_watchdog(1'b1, 31'($urandom_range(300000)),
                                16'($urandom_range(65535, 1)));
                3: set_watchdog(1'b0, 31'($urandom()), 16'($urandom()));
                4: set_watchdog(1'b1, 31'($urandom_range(50)), 16'd0);
                default: set_watchdog(1'b1, TIMEOUT_TOP, 16'($urandom()));
            endcase
            @(negedge aclk);
            for (int k = 0; k < 40; k++) begin
                r = $urandom_range(99);
                if (r < 40)      act = pidw_pkg::ACT_TICK;
                else if (r < 65) act = pidw_pkg::ACT_START;
                else if (r < 82) act = pidw_pkg::ACT_REQUEST;
                else             act = pidw_pkg::ACT_STOP;
                queue_item(act, 4'($urandom_range(15)));
            end
            settle();
        end

        // long run without idling: a few ports build up large counts
        set_watchdog(1'b1, 31'd200000, TICK_TOP);
        @(negedge aclk);
        steady_flow = 1'b1;
        for (int p = 0; p < N_PORTS; p++) queue_item(pidw_pkg::ACT_STOP, 4'(p));
        queue_item(pidw_pkg::ACT_START, 4'd7);
        queue_item(pidw_pkg::ACT_START, 4'd0);
        queue_item(pidw_pkg::ACT_START, 4'd15);
        for (int k = 0; k < 16; k++) queue_item(pidw_pkg::ACT_TICK, 4'($urandom_range(15)));
        queue_item(pidw_pkg::ACT_STOP, 4'd7);
        queue_item(pidw_pkg::ACT_TICK, 4'd7);
        settle();
        steady_flow = 1'b0;

        if (close_expect_q.size() != 0) begin
            $display("%0t: %0d close results never arrived, first port %0d idle %0d",
                     $time, close_expect_q.size(), close_expect_q[0].close_port,
                     close_expect_q[0].idle_time);
            fault_cnt++;
        end
        if (fault_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/pidw_pkg.sv
hdl/pidw_update.sv
hdl/pidw_count_mem.sv
hdl/port_idle_watchdog_bank_unit.sv
tb/sv/port_idle_watchdog_bank_unit_tb.sv
